// ===== rtl/ukf_pkg.sv =====
package ukf_pkg;

   localparam int DEPTH   = 64;
   localparam int KEY_W   = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_DUP   = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd3;

   // controls broadcast to every cell of the row
   typedef struct packed {
      logic capture;   // register the compare result against cmp_key
      logic shift;     // every cell takes its upper neighbor's key
   } ukf_cell_ctrl_type;

endpackage

// ===== rtl/ukf_cell.sv =====
module ukf_cell
   import ukf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ukf_cell_ctrl_type ctrl,
   input  logic              live,
   input  logic              load,
   input  logic [KEY_W-1:0]  cmp_key,
   input  logic [KEY_W-1:0]  upper_key,
   output logic [KEY_W-1:0]  key,
   output logic              match
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             match_ff;
   logic             match_in;

   always_comb begin
      key_in = key_ff;
      if (ctrl.shift) begin
         key_in = upper_key;
      end else if (load) begin
         key_in = cmp_key;
      end
      match_in = match_ff;
      if (ctrl.capture) begin
         match_in = live && (key_ff == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign key   = key_ff;
   assign match = match_ff;

endmodule

// ===== rtl/unique_key_fifo.sv =====
// Duplicate-refusing key FIFO built as a row of DEPTH cells; the oldest key
// always sits in cell 0. At acceptance every cell compares its key against
// the incoming key and registers a hit; once the output register is free or
// being drained, the hits are ORed and the insert, remove or search is applied
// (a remove shifts the whole row down by one, an insert loads the cell at the
// current fill level). The result is held in an output register, so the
// next item is accepted while a result still waits; a stalled result holds
// back only the update of the following item. No clearing pass after reset.
module unique_key_fifo
   import ukf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key[31:0]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // removed_key[31:0], found[32], occupancy[39:33]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type         state_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [KEY_W-1:0]  rsp_removed_ff;
   logic              rsp_found_ff;
   logic [CNT_W-1:0]  rsp_occ_ff;

   logic              req_fire;
   logic              exec_go;
   logic              dup;
   logic              ins_ok;
   logic              rem_ok;
   logic [STAT_W-1:0] status_in;
   logic [KEY_W-1:0]  removed_in;
   logic              found_in;

   ukf_cell_ctrl_type cell_ctrl;
   logic [KEY_W-1:0]  cell_key   [DEPTH];
   logic [DEPTH-1:0]  cell_match;
   logic [DEPTH-1:0]  cell_live;
   logic [DEPTH-1:0]  cell_load;
   logic [KEY_W-1:0]  cmp_key;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // compare against the incoming key at acceptance, load the latched one later
   assign cmp_key = req_fire ? req_tdata : key_ff;

   assign dup    = |cell_match;
   assign ins_ok = exec_go && (mode_ff == MODE_INSERT) &&
                   (count_ff != CNT_W'(DEPTH)) && !dup;
   assign rem_ok = exec_go && (mode_ff == MODE_REMOVE) && (count_ff != '0);

   assign cell_ctrl.capture = req_fire;
   assign cell_ctrl.shift   = rem_ok;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_live[i] = (CNT_W'(i) < count_ff);
      assign cell_load[i] = ins_ok && (count_ff[IDX_W-1:0] == IDX_W'(i));

      ukf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .live      (cell_live[i]),
         .load      (cell_load[i]),
         .cmp_key   (cmp_key),
         .upper_key ((i == DEPTH - 1) ? '0 : cell_key[(i + 1) % DEPTH]),
         .key       (cell_key[i]),
         .match     (cell_match[i])
      );
   end

   always_comb begin
      status_in  = STATUS_OK;
      removed_in = '0;
      found_in   = 1'b0;
      count_in   = count_ff;
      unique case (mode_ff)
         MODE_INSERT: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status_in = STATUS_FULL;
            end else if (dup) begin
               status_in = STATUS_DUP;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_REMOVE: begin
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               removed_in = cell_key[0];
               count_in   = count_ff - CNT_W'(1);
            end
         end
         MODE_SEARCH: begin
            found_in = dup;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_tuser;
         key_ff  <= req_tdata;
      end
      if (exec_go) begin
         rsp_status_ff  <= status_in;
         rsp_removed_ff <= removed_in;
         rsp_found_ff   <= found_in;
         rsp_occ_ff     <= count_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (exec_go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_found_ff, rsp_removed_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill level above depth");

   a_full_occ : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_FULL) |-> rsp_occ_ff == CNT_W'(DEPTH))
      else $error("full status with free entries");

   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_EMPTY) |->
         (rsp_removed_ff == '0) && (rsp_occ_ff == '0))
      else $error("empty status with data or entries");

   a_occ_track : assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_occ_ff == count_ff)
      else $error("reported occupancy differs from fill level");

endmodule
